/* rtl/core/dpsp_pkg.sv */
`default_nettype none

package dpsp_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [31:0] page_size;
      logic        overflow;
   } rsp_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_DIGIT9 = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_KILO   = 8'h4B;
   localparam logic [7:0] CH_MEGA   = 8'h4D;

   typedef enum logic [3:0] {
      CLS_NUL,
      CLS_AT,
      CLS_SLASH,
      CLS_STAR,
      CLS_DIGIT,
      CLS_SPACE,
      CLS_KILO,
      CLS_MEGA,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic           first;
      char_class_type cls;
      logic [3:0]     digit;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_NAME,
      PH_ADDR,
      PH_COUNT,
      PH_SIZE,
      PH_SPACES
   } phase_type;

endpackage

`default_nettype wire

/* rtl/core/dpsp_front.sv */
`default_nettype none

module dpsp_front (
   input  wire logic             req_push,
   input  wire dpsp_pkg::req_type req_data,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output dpsp_pkg::cmd_type     cmd
);
   import dpsp_pkg::*;

   // Each character is reduced to a class code so the back end never compares bytes.
   always_comb begin
      cmd.first = req_data.first;
      cmd.digit = req_data.ch[3:0];
      case (req_data.ch) inside
         CH_NUL:                 cmd.cls = CLS_NUL;
         CH_AT:                  cmd.cls = CLS_AT;
         CH_SLASH:               cmd.cls = CLS_SLASH;
         CH_STAR:                cmd.cls = CLS_STAR;
         [CH_DIGIT0:CH_DIGIT9]:  cmd.cls = CLS_DIGIT;
         CH_SPACE:               cmd.cls = CLS_SPACE;
         CH_KILO:                cmd.cls = CLS_KILO;
         CH_MEGA:                cmd.cls = CLS_MEGA;
         default:                cmd.cls = CLS_OTHER;
      endcase
   end

   assign cmd_push = req_push && !cmd_full;

endmodule

`default_nettype wire

/* rtl/core/dpsp_cmd_queue.sv */
`default_nettype none

module dpsp_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dpsp_pkg::cmd_type cmd_in,
   input  wire logic              pop,
   output logic                   full,
   output logic                   valid,
   output dpsp_pkg::cmd_type      cmd_out
);
   import dpsp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign cmd_out = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dpsp_back.sv */
`default_nettype none

module dpsp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire dpsp_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output dpsp_pkg::rsp_type      rsp_data
);
   import dpsp_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [31:0]  accum_ff, accum_in;
   logic         wrapped_ff, wrapped_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_ff, out_in;

   logic         take;
   logic         emit;
   rsp_type      result;
   logic [35:0]  times_ten;
   rsp_type      scaled;

   assign take      = cmd_valid && (!out_valid_ff || rsp_pop);
   assign cmd_pop   = take;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // accum * 10 + digit, as (accum << 3) + (accum << 1) + digit.
   assign times_ten = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                      + {32'd0, cmd.digit};

   // The size is decided on the first character after the digits and spaces.
   always_comb begin
      scaled.overflow  = wrapped_ff;
      scaled.page_size = accum_ff;
      if (cmd.cls == CLS_KILO) begin
         scaled.overflow  = wrapped_ff || (accum_ff[31:22] != '0);
         scaled.page_size = {accum_ff[21:0], 10'd0};
      end else if (cmd.cls == CLS_MEGA) begin
         scaled.overflow  = wrapped_ff || (accum_ff[31:12] != '0);
         scaled.page_size = {accum_ff[11:0], 20'd0};
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      wrapped_in = wrapped_ff;
      emit       = 1'b0;
      result     = '0;

      if (cmd.first) begin
         accum_in   = '0;
         wrapped_in = 1'b0;
         if (cmd.cls == CLS_AT) begin
            phase_in = PH_NAME;
         end else begin
            emit = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_NAME, PH_ADDR: begin
               if (cmd.cls == CLS_NUL) begin
                  emit = 1'b1;
               end else if (cmd.cls == CLS_SLASH) begin
                  phase_in = (phase_ff == PH_NAME) ? PH_ADDR : PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (cmd.cls == CLS_NUL) begin
                  emit = 1'b1;
               end else if (cmd.cls == CLS_STAR) begin
                  phase_in   = PH_SIZE;
                  accum_in   = '0;
                  wrapped_in = 1'b0;
               end
            end
            PH_SIZE: begin
               if (cmd.cls == CLS_NUL) begin
                  emit = 1'b1;
               end else if (cmd.cls == CLS_DIGIT) begin
                  accum_in   = times_ten[31:0];
                  wrapped_in = wrapped_ff || (times_ten[35:32] != '0);
               end else if (cmd.cls == CLS_SPACE) begin
                  phase_in = PH_SPACES;
               end else begin
                  emit   = 1'b1;
                  result = scaled;
               end
            end
            PH_SPACES: begin
               if (cmd.cls == CLS_NUL) begin
                  emit = 1'b1;
               end else if (cmd.cls != CLS_SPACE) begin
                  emit   = 1'b1;
                  result = scaled;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end

      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take && emit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         accum_ff     <= '0;
         wrapped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            accum_ff   <= accum_in;
            wrapped_ff <= wrapped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

/* rtl/core/dfuse_page_size_parser_unit.sv */
// Page-size parser for a DfuSe memory-layout descriptor such as "@name/addr/8*2Ka". Push one
// character per item with first set on the leading character and a zero byte at the end; one
// result (page size, or 0 on a malformed or early-ended string, plus a wrap flag) is queued as
// soon as the outcome is decided, and characters up to the next first flag are dropped. The
// block sustains one character per clock: a classifier feeds a CMD_DEPTH-entry command queue,
// and the parser behind it retires one command per cycle, pausing only while its single result
// register is full and not being popped. A result passes through the command queue and then the
// result register before it is visible.
`default_nettype none

module dfuse_page_size_parser_unit #(
   parameter int CMD_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire dpsp_pkg::req_type req_data,
   output logic                   full,
   output logic                   empty,
   input  wire logic              pop,
   output dpsp_pkg::rsp_type      rsp_data
);
   import dpsp_pkg::*;

   logic    cmd_push;
   cmd_type cmd_front;
   logic    cmd_full;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_back;

   assign full = cmd_full;

   dpsp_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_front)
   );

   dpsp_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .cmd_in  (cmd_front),
      .pop     (cmd_pop),
      .full    (cmd_full),
      .valid   (cmd_valid),
      .cmd_out (cmd_back)
   );

   dpsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_back),
      .cmd_pop   (cmd_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
